// File: src/fmac_pkg.sv
// Shared types and constants for the fire and motion alarm controller.
// Depends on nothing; every other file imports it.
package fmac_pkg;

    // Input op codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_TEMP = 2'd1;
    localparam logic [1:0] OP_GYRO = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP_LIMIT    = 2'd0;
    localparam logic [1:0] REG_SENSITIVITY   = 2'd1;
    localparam logic [1:0] REG_ALARM_SECONDS = 2'd2;

    localparam logic [6:0] TEMP_LIMIT_RST    = 7'd30;
    localparam logic [3:0] SENSITIVITY_RST   = 4'd5;
    localparam logic [5:0] ALARM_SECONDS_RST = 6'd30;

    // Run of large gyro beats needed for the motion alarm, beeper length in ms
    localparam logic [2:0] RUN_NEEDED = 3'd5;
    localparam logic [6:0] BEEP_MS    = 7'd100;

    // Tone period in us for each tone select (1e6 / frequency)
    localparam logic [10:0] TONE_PERIOD_US [8] = '{
        11'd2024, 11'd1912, 11'd1700, 11'd1515,
        11'd1432, 11'd1275, 11'd1136, 11'd1012
    };

    typedef struct packed {
        logic [1:0]         op;
        logic signed [11:0] temp_q4;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } in_t;

    typedef struct packed {
        logic        heat_alarm;
        logic        shake_alarm;
        logic        digits_shown;
        logic [3:0]  digit_ten_sec;
        logic [3:0]  digit_sec;
        logic [3:0]  digit_tenth;
        logic [3:0]  digit_hundredth;
        logic        beep_on;
        logic [10:0] beep_period_us;
    } out_t;

    typedef struct packed {
        logic [6:0] temp_limit;
        logic [3:0] sensitivity;
        logic [5:0] alarm_seconds;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_TEMP,
        KIND_GYRO,
        KIND_NOP
    } kind_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        kind_t kind;
        logic  hit;     // temp: latches heat alarm; gyro: large sample
    } cmd_t;

endpackage

// File: src/fmac_front.sv
// Front end: decodes each input beat and classifies it in two stages
// (squares, then sum and compare). Depends on fmac_pkg.
module fmac_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_take,
    input  fmac_pkg::in_t in_beat,
    input  fmac_pkg::cfg_t cfg,
    output logic          cmd_valid,
    output fmac_pkg::cmd_t cmd,
    output logic [1:0]    inflight
);
    import fmac_pkg::*;

    logic        v1_reg;
    kind_t       kind1_reg;
    logic        temp_hit1_reg;
    logic [30:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic        v2_reg;
    cmd_t        cmd2_reg;

    kind_t              kind1_next;
    logic               temp_hit1_next;
    logic signed [31:0] px, py, pz;
    logic signed [11:0] limit_q4;
    logic signed [15:0] mag_lim;
    logic [32:0]        mag;
    logic               big;
    logic               armed;
    cmd_t               cmd2_next;

    assign armed = (cfg.alarm_seconds != 6'd0);

    always_comb
    begin
        case (in_beat.op)
            OP_TICK: kind1_next = KIND_TICK;
            OP_TEMP: kind1_next = KIND_TEMP;
            OP_GYRO: kind1_next = KIND_GYRO;
            default: kind1_next = KIND_NOP;
        endcase
        limit_q4 = $signed({1'b0, cfg.temp_limit, 4'b0000});
        temp_hit1_next = (in_beat.temp_q4 < 12'sd2000) && (in_beat.temp_q4 >= limit_q4)
                         && armed;
        px = in_beat.rate_x * in_beat.rate_x;
        py = in_beat.rate_y * in_beat.rate_y;
        pz = in_beat.rate_z * in_beat.rate_z;
    end

    // Stage two: magnitude against 2000 * (10 - sensitivity), negative limit always passes
    always_comb
    begin
        mag_lim = 16'sd2000 * (16'sd10 - $signed({12'd0, cfg.sensitivity}));
        mag = {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};
        big = mag_lim[15] || (mag > {17'd0, mag_lim});
        cmd2_next.kind = kind1_reg;
        case (kind1_reg)
            KIND_TEMP: cmd2_next.hit = temp_hit1_reg;
            KIND_GYRO: cmd2_next.hit = big && armed;
            default:   cmd2_next.hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_take;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind1_reg     <= kind1_next;
        temp_hit1_reg <= temp_hit1_next;
        sq_x_reg      <= px[30:0];
        sq_y_reg      <= py[30:0];
        sq_z_reg      <= pz[30:0];
        cmd2_reg      <= cmd2_next;
    end

    assign cmd_valid = v2_reg;
    assign cmd       = cmd2_reg;
    assign inflight  = {1'b0, v1_reg} + {1'b0, v2_reg};

endmodule

// File: src/fmac_queue.sv
// Short queue of classified items between the front and the back.
// Depends on fmac_pkg.
module fmac_queue #(
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  fmac_pkg::cmd_t               push_cmd,
    input  logic                         pop,
    output logic                         not_empty,
    output fmac_pkg::cmd_t               head,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import fmac_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: src/fmac_back.sv
// Back end: alarm latches, motion run counter, BCD countdown and beeper,
// plus the output register. Depends on fmac_pkg.
module fmac_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  fmac_pkg::cmd_t cmd,
    input  fmac_pkg::cfg_t cfg,
    output logic           cmd_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output fmac_pkg::out_t out_data
);
    import fmac_pkg::*;

    logic            heat_reg, heat_next;
    logic            shake_reg, shake_next;
    logic [2:0]      over_run_reg, over_run_next;
    logic            active_reg, active_next;
    logic [4:0][3:0] bcd_reg, bcd_next;     // remaining ms, digit 0 is units
    logic [6:0]      beep_left_reg, beep_left_next;
    logic [2:0]      tone_reg, tone_next;
    logic            out_valid_reg;
    out_t            out_reg, out_next;

    logic [4:0][3:0] bcd_dec;
    logic [4:0][3:0] bcd_load;
    logic            bcd_le_one;
    logic            borrow;
    logic [2:0]      over_inc;
    logic [3:0]      hund;
    logic            shown;
    logic            start;

    function automatic logic [7:0] sec_to_bcd(input logic [5:0] s);
        logic [3:0] tens;
        logic [5:0] rest;
        tens = 4'd0;
        rest = s;
        for (int i = 1; i <= 6; i++)
        begin
            if (s >= 6'(10 * i))
            begin
                tens = 4'(i);
                rest = s - 6'(10 * i);
            end
        end
        return {tens, rest[3:0]};
    endfunction

    assign cmd_pop = cmd_valid && (!out_valid_reg || !out_stall);

    // Countdown helpers: BCD decrement, load of alarm_seconds * 1000
    always_comb
    begin
        borrow = 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            bcd_dec[i] = bcd_reg[i];
            if (borrow)
            begin
                if (bcd_reg[i] == 4'd0)
                begin
                    bcd_dec[i] = 4'd9;
                end
                else
                begin
                    bcd_dec[i] = bcd_reg[i] - 4'd1;
                    borrow     = 1'b0;
                end
            end
        end
        bcd_load      = '0;
        bcd_load[4:3] = sec_to_bcd(cfg.alarm_seconds);
        bcd_le_one    = (bcd_reg[4:1] == '0) && (bcd_reg[0] <= 4'd1);
        over_inc      = (over_run_reg < RUN_NEEDED) ? over_run_reg + 3'd1 : over_run_reg;
    end

    always_comb
    begin
        heat_next      = heat_reg;
        shake_next     = shake_reg;
        over_run_next  = over_run_reg;
        active_next    = active_reg;
        bcd_next       = bcd_reg;
        beep_left_next = beep_left_reg;
        tone_next      = tone_reg;
        shown          = 1'b0;
        start          = 1'b0;
        hund           = bcd_dec[2];
        case (cmd.kind)
            KIND_TICK:
            begin
                if (beep_left_reg != 7'd0)
                begin
                    beep_left_next = beep_left_reg - 7'd1;
                end
                if ((heat_reg || shake_reg) && cfg.alarm_seconds != 6'd0)
                begin
                    if (!active_reg)
                    begin
                        active_next = 1'b1;
                        bcd_next    = bcd_load;
                    end
                    else if (bcd_le_one)
                    begin
                        heat_next   = 1'b0;
                        shake_next  = 1'b0;
                        active_next = 1'b0;
                        bcd_next    = '0;
                    end
                    else
                    begin
                        bcd_next = bcd_dec;
                        shown    = 1'b1;
                        // heat alarm beeps on tenths 1, 3, 5; motion alarm on 1 to 7
                        if (heat_reg)
                        begin
                            start = (hund == 4'd1) || (hund == 4'd3) || (hund == 4'd5);
                        end
                        else
                        begin
                            start = (hund != 4'd0) && (hund <= 4'd7);
                        end
                        if (start)
                        begin
                            tone_next      = hund[2:0];
                            beep_left_next = BEEP_MS;
                        end
                    end
                end
                if (beep_left_next == 7'd0)
                begin
                    tone_next = 3'd0;
                end
            end
            KIND_TEMP:
            begin
                if (cmd.hit)
                begin
                    heat_next = 1'b1;
                end
            end
            KIND_GYRO:
            begin
                if (cmd.hit)
                begin
                    over_run_next = over_inc;
                    if (over_inc >= RUN_NEEDED && cfg.sensitivity != 4'd0)
                    begin
                        shake_next = 1'b1;
                    end
                end
                else
                begin
                    over_run_next = 3'd0;
                end
            end
            default:
            begin
            end
        endcase

        out_next.heat_alarm      = heat_next;
        out_next.shake_alarm     = shake_next;
        out_next.digits_shown    = shown;
        out_next.digit_ten_sec   = shown ? bcd_dec[4] : 4'd0;
        out_next.digit_sec       = shown ? bcd_dec[3] : 4'd0;
        out_next.digit_tenth     = shown ? bcd_dec[2] : 4'd0;
        out_next.digit_hundredth = shown ? bcd_dec[1] : 4'd0;
        out_next.beep_on         = (beep_left_next != 7'd0);
        out_next.beep_period_us  = out_next.beep_on ? TONE_PERIOD_US[tone_next] : 11'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_reg      <= 1'b0;
            shake_reg     <= 1'b0;
            over_run_reg  <= 3'd0;
            active_reg    <= 1'b0;
            bcd_reg       <= '0;
            beep_left_reg <= 7'd0;
            tone_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                heat_reg      <= heat_next;
                shake_reg     <= shake_next;
                over_run_reg  <= over_run_next;
                active_reg    <= active_next;
                bcd_reg       <= bcd_next;
                beep_left_reg <= beep_left_next;
                tone_reg      <= tone_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: src/fire_motion_alarm_controller.sv
// Top level of the fire and motion alarm controller: configuration registers,
// front classifier, item queue and back end. Depends on fmac_pkg, fmac_front,
// fmac_queue and fmac_back.
//   channel  | beat                 | handshake
//   ---------+----------------------+------------------------------
//   in       | in_data  (in_t)      | in_valid / in_stall
//   out      | out_data (out_t)     | out_valid / out_stall
//   cfg      | cfg_index, cfg_data  | cfg_we, no wait
//
// One item per clock sustained while the output is not stalled; an input beat
// goes through the two front stages, the queue and the output register.
// The front takes a beat whenever the queue plus items in flight in the
// front stay below QUEUE_DEPTH; the gyro squarers set the front depth.
// Reset clears alarms, countdown and beeper and loads register defaults.
// A stalled output holds its beat while up to QUEUE_DEPTH items back up.
module fire_motion_alarm_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  fmac_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output fmac_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [6:0]     cfg_data
);
    import fmac_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 3);

    cfg_t             cfg_reg;
    logic             in_take;
    logic             cmd_valid;
    cmd_t             cmd;
    logic [1:0]       inflight;
    logic             q_not_empty;
    cmd_t             q_head;
    logic [CNT_W-1:0] q_count;
    logic             q_pop;
    logic [OCC_W-1:0] occupancy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_limit    <= TEMP_LIMIT_RST;
            cfg_reg.sensitivity   <= SENSITIVITY_RST;
            cfg_reg.alarm_seconds <= ALARM_SECONDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP_LIMIT:    cfg_reg.temp_limit    <= cfg_data;
                REG_SENSITIVITY:   cfg_reg.sensitivity   <= cfg_data[3:0];
                REG_ALARM_SECONDS: cfg_reg.alarm_seconds <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // Reserve a queue slot for every beat still inside the front stages
    assign occupancy = OCC_W'(q_count) + OCC_W'(inflight);
    assign in_stall  = (occupancy >= OCC_W'(QUEUE_DEPTH));
    assign in_take   = in_valid && !in_stall;

    fmac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .in_beat   (in_data),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .inflight  (inflight)
    );

    fmac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_cmd  (cmd),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    fmac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cfg       (cfg_reg),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: src/fmac_checker.sv
// Port-level checks for the fire and motion alarm controller, bound to the
// top level. Depends on fmac_pkg.
module fmac_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input fmac_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_stall,
    input fmac_pkg::out_t out_data
);
    import fmac_pkg::*;

    // Hold a stalled input beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input beat changed");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    a_blank_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.digits_shown |->
            out_data.digit_ten_sec == 4'd0 && out_data.digit_sec == 4'd0 &&
            out_data.digit_tenth == 4'd0 && out_data.digit_hundredth == 4'd0)
        else $error("blank display with nonzero digits");

    // A 63 s alarm shows at most 62999 ms, so the top digit stops at 6
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.digits_shown |->
            out_data.digit_ten_sec <= 4'd6 && out_data.digit_sec <= 4'd9 &&
            out_data.digit_tenth <= 4'd9 && out_data.digit_hundredth <= 4'd9 &&
            (out_data.heat_alarm || out_data.shake_alarm))
        else $error("countdown digits out of range or shown without alarm");

    a_beep_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.beep_on == (out_data.beep_period_us != 11'd0))
        else $error("beeper state and tone period disagree");

endmodule

bind fire_motion_alarm_controller fmac_checker u_fmac_checker (.*);

// File: verif/tb.sv
// Testbench for fire_motion_alarm_controller: directed and random beats, with an
// in-bench alarm predictor that checks each result beat in order.
// Depends on fmac_pkg and the controller top level.
module tb;
    import fmac_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RUN_LEN     = 5;
    localparam int         BEEP_LEN_MS = 100;

    class alarm_scoreboard;
        bit [6:0]  limit_deg = 7'd30;
        bit [3:0]  sens      = 4'd5;
        bit [5:0]  alarm_s   = 6'd30;
        bit        heat, shake, counting;
        bit [2:0]  run_len;
        bit [15:0] remaining;
        bit [6:0]  beep_left;
        bit [2:0]  tone;
        out_t      expected_status[$];
        int        errors;

        function void set_reg(logic [1:0] idx, int val);
            case (idx)
                REG_TEMP_LIMIT:    limit_deg = 7'(val);
                REG_SENSITIVITY:   sens      = 4'(val);
                REG_ALARM_SECONDS: alarm_s   = 6'(val);
                default: ;
            endcase
        endfunction

        function int tone_hz(bit [2:0] sel);
            case (sel)
                3'd0: return 494;
                3'd1: return 523;
                3'd2: return 588;
                3'd3: return 660;
                3'd4: return 698;
                3'd5: return 784;
                3'd6: return 880;
                default: return 988;
            endcase
        endfunction

        function void start_tone(int digit);
            if (digit >= 1 && digit <= 7)
            begin
                tone      = 3'(digit);
                beep_left = 7'(BEEP_LEN_MS);
            end
        endfunction

        function void note_item(in_t it);
            out_t   r;
            int     d0, d1, d2, d3, t, rem;
            bit     shown;
            longint x, y, z, mag, thr;
            r = '0;
            shown = 1'b0;
            d0 = 0; d1 = 0; d2 = 0; d3 = 0;
            case (it.op)
                OP_TICK:
                begin
                    if (beep_left != 0)
                        beep_left--;
                    if ((heat || shake) && alarm_s != 0)
                    begin
                        if (!counting)
                        begin
                            counting  = 1'b1;
                            remaining = 16'(alarm_s * 1000);
                        end
                        else if (remaining <= 1)
                        begin
                            heat      = 1'b0;
                            shake     = 1'b0;
                            counting  = 1'b0;
                            remaining = '0;
                        end
                        else
                        begin
                            remaining--;
                            rem = int'(remaining);
                            d0 = (rem / 10000) % 10;
                            d1 = (rem / 1000) % 10;
                            d2 = (rem / 100) % 10;
                            d3 = (rem / 10) % 10;
                            shown = 1'b1;
                            // heat picks only the odd low tenths, shake alone any of 1..7
                            if (heat)
                            begin
                                if (d2 == 1 || d2 == 3 || d2 == 5)
                                    start_tone(d2);
                            end
                            else if (d2 != 0)
                            begin
                                start_tone(d2);
                            end
                        end
                    end
                    if (beep_left == 0)
                        tone = '0;
                end
                OP_TEMP:
                begin
                    t = int'(signed'(it.temp_q4));
                    if (t < 2000 && t >= 16 * int'(limit_deg) && alarm_s != 0)
                        heat = 1'b1;
                end
                OP_GYRO:
                begin
                    x = longint'(signed'(it.rate_x));
                    y = longint'(signed'(it.rate_y));
                    z = longint'(signed'(it.rate_z));
                    mag = x * x + y * y + z * z;
                    thr = 2000 * (10 - longint'(sens));
                    if (mag > thr && alarm_s != 0)
                    begin
                        if (run_len < RUN_LEN)
                            run_len++;
                        if (run_len >= RUN_LEN && sens > 0)
                            shake = 1'b1;
                    end
                    else
                    begin
                        run_len = '0;
                    end
                end
                default: ;
            endcase
            r.heat_alarm   = heat;
            r.shake_alarm  = shake;
            r.digits_shown = shown;
            if (shown)
            begin
                r.digit_ten_sec   = 4'(d0);
                r.digit_sec       = 4'(d1);
                r.digit_tenth     = 4'(d2);
                r.digit_hundredth = 4'(d3);
            end
            if (beep_left != 0)
            begin
                r.beep_on        = 1'b1;
                r.beep_period_us = 11'(1000000 / tone_hz(tone));
            end
            expected_status.push_back(r);
        endfunction

        function void cmp(string name, logic [15:0] e, logic [15:0] g);
            if (g !== e)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, e, g);
                errors++;
            end
        endfunction

        function void check_result(out_t got);
            out_t e;
            if (expected_status.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                errors++;
                return;
            end
            e = expected_status.pop_front();
            cmp("heat_alarm", 16'(e.heat_alarm), 16'(got.heat_alarm));
            cmp("shake_alarm", 16'(e.shake_alarm), 16'(got.shake_alarm));
            cmp("digits_shown", 16'(e.digits_shown), 16'(got.digits_shown));
            cmp("digit_ten_sec", 16'(e.digit_ten_sec), 16'(got.digit_ten_sec));
            cmp("digit_sec", 16'(e.digit_sec), 16'(got.digit_sec));
            cmp("digit_tenth", 16'(e.digit_tenth), 16'(got.digit_tenth));
            cmp("digit_hundredth", 16'(e.digit_hundredth), 16'(got.digit_hundredth));
            cmp("beep_on", 16'(e.beep_on), 16'(got.beep_on));
            cmp("beep_period_us", 16'(e.beep_period_us), 16'(got.beep_period_us));
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_t        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = REG_TEMP_LIMIT;
    logic [6:0] cfg_data  = '0;

    alarm_scoreboard sb = new();
    int src_idle_pct;
    int sink_stall_pct;
    int burst_left;
    int cur_limit = 30;

    fire_motion_alarm_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("[fire_motion_alarm_controller] ERROR");
        $finish;
    end

    // Take result beats, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    function automatic void set_idling(int mode);
        case (mode)
            0:
            begin
                src_idle_pct   = 6;
                sink_stall_pct = 68;
            end
            1:
            begin
                src_idle_pct   = 68;
                sink_stall_pct = 6;
            end
            default:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
        endcase
    endfunction

    function automatic int rand_signed(int m);
        int v;
        v = $urandom_range(0, m);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    function automatic in_t make_item(logic [1:0] op, int t, int x, int y, int z);
        in_t it;
        it.op      = op;
        it.temp_q4 = 12'(t);
        it.rate_x  = 16'(x);
        it.rate_y  = 16'(y);
        it.rate_z  = 16'(z);
        return it;
    endfunction

    function automatic in_t random_item(int tick_pct);
        in_t it;
        int  k;
        // fill every field with noise, then shape the ones the op uses
        it.temp_q4 = 12'($urandom);
        it.rate_x  = 16'($urandom);
        it.rate_y  = 16'($urandom);
        it.rate_z  = 16'($urandom);
        if (burst_left > 0)
        begin
            burst_left--;
            it.op = OP_GYRO;
            return it;
        end
        if ($urandom_range(0, 99) < tick_pct)
        begin
            it.op = OP_TICK;
            return it;
        end
        k = $urandom_range(0, 99);
        if (k < 35)
        begin
            it.op = OP_TEMP;
            k = $urandom_range(0, 99);
            if (k < 70)
                it.temp_q4 = 12'(int'($urandom_range(0, 2927)) - 880);
            else if (k < 85)
                it.temp_q4 = 12'(16 * cur_limit + int'($urandom_range(0, 4)) - 2);
        end
        else if (k < 90)
        begin
            it.op = OP_GYRO;
            k = $urandom_range(0, 99);
            if (k < 20)
            begin
                burst_left = $urandom_range(3, 6);
            end
            else if (k < 45)
            begin
                it.rate_x = 16'(rand_signed(60));
                it.rate_y = 16'(rand_signed(60));
                it.rate_z = 16'(rand_signed(60));
            end
            else if (k < 70)
            begin
                it.rate_x = 16'(rand_signed(150));
                it.rate_y = 16'(rand_signed(40));
                it.rate_z = 16'(rand_signed(40));
            end
        end
        else
        begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(in_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(it);
    endtask

    task automatic run_random(int n, int tick_pct);
        burst_left = 0;
        repeat (n)
            send_item(random_item(tick_pct));
        in_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_cfg(int lim, int sens, int secs);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TEMP_LIMIT;
        cfg_data  <= 7'(lim);
        sb.set_reg(REG_TEMP_LIMIT, lim);
        cur_limit = lim;
        @(posedge clk);
        cfg_index <= REG_SENSITIVITY;
        cfg_data  <= 7'(sens);
        sb.set_reg(REG_SENSITIVITY, sens);
        @(posedge clk);
        cfg_index <= REG_ALARM_SECONDS;
        cfg_data  <= 7'(secs);
        sb.set_reg(REG_ALARM_SECONDS, secs);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        set_idling(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, discard at 125 C, gyro threshold edge, alarm start
        send_item(make_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
        send_item(make_item(OP_TEMP, -880, 0, 0, 0));
        send_item(make_item(OP_TEMP, 2047, 0, 0, 0));
        send_item(make_item(OP_TEMP, 2000, 0, 0, 0));
        send_item(make_item(OP_TEMP, 479, 0, 0, 0));
        send_item(make_item(OP_GYRO, 0, 0, 0, 0));
        send_item(make_item(OP_GYRO, 0, -32768, -32768, -32768));
        send_item(make_item(OP_GYRO, 0, 32767, 32767, 32767));
        send_item(make_item(OP_GYRO, 0, 100, 0, 0));
        repeat (6)
            send_item(make_item(OP_GYRO, 0, 100, 1, 0));
        send_item(make_item(OP_TICK, 0, 0, 0, 0));
        send_item(make_item(OP_TICK, 0, 0, 0, 0));
        send_item(make_item(OP_TEMP, 480, 0, 0, 0));
        send_item(make_item(OP_TEMP, -2048, 0, 0, 0));
        send_item(make_item(OP_TICK, 0, 0, 0, 0));
        send_item(make_item(OP_UNUSED, 0, 0, 0, 0));
        in_valid <= 1'b0;

        // Short alarms and odd settings probe the edges
        wait_quiet();
        write_cfg(0, 9, 1);
        run_random(150, 88);
        wait_quiet();
        write_cfg(127, 15, 1);
        run_random(90, 85);
        wait_quiet();
        set_idling(1);
        write_cfg(90, 0, 63);
        run_random(40, 40);
        wait_quiet();
        write_cfg(45, 12, 0);
        run_random(40, 40);
        wait_quiet();
        set_idling(2);
        write_cfg($urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(1, 3));
        run_random(70, 60);
        wait_quiet();
        write_cfg(1, 1, 60);
        run_random(40, 50);

        wait_quiet();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("[fire_motion_alarm_controller] OK");
        else
            $display("[fire_motion_alarm_controller] ERROR");
        $finish;
    end
endmodule
